FILE: design/rrf_pkg.sv
// Shared constants and types for the request framer.
package rrf_pkg;

  localparam int LENGTH_BITS = 24;
  localparam int COUNT_BITS  = 16;
  localparam int PHASE_BITS  = 4;

  localparam logic [LENGTH_BITS-1:0] LEN_MAX = {LENGTH_BITS{1'b1}};
  localparam logic [COUNT_BITS-1:0]  CNT_MAX = {COUNT_BITS{1'b1}};

  localparam logic [LENGTH_BITS-1:0] MAX_LEN_RESET = LENGTH_BITS'(2097152);

  localparam logic [PHASE_BITS-1:0] PH_ARRAY      = 4'd0;
  localparam logic [PHASE_BITS-1:0] PH_NUM_FIRST  = 4'd1;
  localparam logic [PHASE_BITS-1:0] PH_NUM_SIGN   = 4'd2;
  localparam logic [PHASE_BITS-1:0] PH_NUM_DIGITS = 4'd3;
  localparam logic [PHASE_BITS-1:0] PH_NUM_LF     = 4'd4;
  localparam logic [PHASE_BITS-1:0] PH_LINE       = 4'd5;
  localparam logic [PHASE_BITS-1:0] PH_DATA       = 4'd6;
  localparam logic [PHASE_BITS-1:0] PH_DATA_CR    = 4'd7;
  localparam logic [PHASE_BITS-1:0] PH_DATA_LF    = 4'd8;

  localparam logic [1:0] KIND_COUNT = 2'd0;
  localparam logic [1:0] KIND_BULK  = 2'd1;
  localparam logic [1:0] KIND_INT   = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_PROTO = 2'd1;
  localparam logic [1:0] ST_BIG   = 2'd2;

  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;

  typedef struct packed {
    logic                   package_done;
    logic [1:0]             status;
    logic [LENGTH_BITS-1:0] req_length;
    logic [COUNT_BITS-1:0]  lines_done;
  } rrf_result_t;

  typedef struct packed {
    logic       full;
    logic [7:0] data_byte;
  } rrf_item_t;

endpackage

FILE: design/rrf_ifs.sv
// Channel interfaces: byte input, result output, configuration write.
interface rrf_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

interface rrf_result_if;
  import rrf_pkg::*;
  logic                   valid;
  logic                   ready;
  logic                   package_done;
  logic [1:0]             status;
  logic [LENGTH_BITS-1:0] req_length;
  logic [COUNT_BITS-1:0]  lines_done;
  modport source (output valid, output package_done, output status,
                  output req_length, output lines_done, input ready);
  modport sink   (input valid, input package_done, input status,
                  input req_length, input lines_done, output ready);
endinterface

interface rrf_cfg_if;
  import rrf_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [LENGTH_BITS-1:0] max_req_length;
  modport source (output valid, output max_req_length, input ready);
  modport sink   (input valid, input max_req_length, output ready);
endinterface

FILE: design/rrf_in_reg.sv
// Input register: holds one received byte until the parser takes it.
module rrf_in_reg (
  input  logic              clk,
  input  logic              rst,
  rrf_byte_if.sink          data,
  input  logic              take,
  output rrf_pkg::rrf_item_t item
);
  import rrf_pkg::*;

  logic       full;
  logic [7:0] data_byte;

  assign data.ready = !full || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (data.ready) begin
      full <= data.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (data.valid && data.ready) begin
      data_byte <= data.data_byte;
    end
  end

  assign item.full      = full;
  assign item.data_byte = data_byte;
endmodule

FILE: design/rrf_parse.sv
// Framing state machine: one step per byte, number accumulation and limits.
module rrf_parse (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                step,
  input  logic [7:0]                          data_byte,
  input  logic [rrf_pkg::LENGTH_BITS-1:0]     max_len,
  output rrf_pkg::rrf_result_t                res
);
  import rrf_pkg::*;

  logic [PHASE_BITS-1:0]  phase, phase_next;
  logic [LENGTH_BITS-1:0] acc, acc_next;
  logic                   neg, neg_next;
  logic [1:0]             kind, kind_next;
  logic [COUNT_BITS-1:0]  lines_exp, lines_exp_next;
  logic [COUNT_BITS-1:0]  lines_seen, lines_seen_next;
  logic [LENGTH_BITS-1:0] bulk_left, bulk_left_next;
  logic [LENGTH_BITS-1:0] bytes, bytes_next;

  logic [LENGTH_BITS-1:0] bytes_inc;
  logic                   is_digit;
  logic [LENGTH_BITS+3:0] acc_mul;
  logic [LENGTH_BITS-1:0] acc_dig;
  logic [COUNT_BITS-1:0]  lines_inc;
  logic                   fin_done;
  logic [LENGTH_BITS:0]   bulk_sum;
  logic                   neg_val;
  logic [COUNT_BITS-1:0]  cnt_sat;
  logic [1:0]             status;
  logic                   done;
  logic [COUNT_BITS-1:0]  lines_out;

  assign bytes_inc = (bytes != LEN_MAX) ? bytes + 1'b1 : bytes;
  assign is_digit  = (data_byte >= CH_ZERO) && (data_byte <= CH_NINE);
  // acc * 10 + digit as shifts
  assign acc_mul   = ({4'd0, acc} << 3) + ({4'd0, acc} << 1)
                     + {{(LENGTH_BITS){1'b0}}, data_byte[3:0]};
  assign acc_dig   = (acc_mul > {4'd0, LEN_MAX}) ? LEN_MAX : acc_mul[LENGTH_BITS-1:0];
  assign lines_inc = (lines_seen != CNT_MAX) ? lines_seen + 1'b1 : lines_seen;
  assign fin_done  = lines_inc >= lines_exp;
  assign bulk_sum  = {1'b0, bytes_inc} + {1'b0, acc};
  assign neg_val   = neg && (acc != '0);
  assign cnt_sat   = (acc > LENGTH_BITS'(CNT_MAX)) ? CNT_MAX : acc[COUNT_BITS-1:0];

  always_comb begin
    phase_next      = phase;
    acc_next        = acc;
    neg_next        = neg;
    kind_next       = kind;
    lines_exp_next  = lines_exp;
    lines_seen_next = lines_seen;
    bulk_left_next  = bulk_left;
    bytes_next      = bytes_inc;
    status          = ST_OK;
    done            = 1'b0;

    if (bytes_inc > max_len) begin
      status = ST_BIG;
    end else begin
      case (phase)
        PH_ARRAY: begin
          if (data_byte == CH_STAR) begin
            kind_next  = KIND_COUNT;
            acc_next   = '0;
            neg_next   = 1'b0;
            phase_next = PH_NUM_FIRST;
          end else begin
            status = ST_PROTO;
          end
        end
        PH_NUM_FIRST: begin
          if (data_byte == CH_MINUS) begin
            neg_next   = 1'b1;
            phase_next = PH_NUM_SIGN;
          end else if (is_digit) begin
            acc_next   = acc_dig;
            phase_next = PH_NUM_DIGITS;
          end else begin
            status = ST_PROTO;
          end
        end
        PH_NUM_SIGN: begin
          if (is_digit) begin
            acc_next   = acc_dig;
            phase_next = PH_NUM_DIGITS;
          end else begin
            status = ST_PROTO;
          end
        end
        PH_NUM_DIGITS: begin
          if (is_digit) begin
            acc_next   = acc_dig;
            phase_next = PH_NUM_DIGITS;
          end else if (data_byte == CH_CR) begin
            phase_next = PH_NUM_LF;
          end else begin
            status = ST_PROTO;
          end
        end
        PH_NUM_LF: begin
          if (data_byte != CH_LF) begin
            status = ST_PROTO;
          end else if (kind == KIND_COUNT) begin
            if (neg_val || acc == '0) begin
              done = 1'b1;
            end else begin
              lines_exp_next = cnt_sat;
              phase_next     = PH_LINE;
            end
          end else if (kind == KIND_BULK) begin
            if (neg_val) begin
              // null bulk closes the line at once
              lines_seen_next = lines_inc;
              phase_next      = PH_LINE;
              done            = fin_done;
            end else if (bulk_sum > {1'b0, max_len}) begin
              status = ST_BIG;
            end else if (acc == '0) begin
              phase_next = PH_DATA_CR;
            end else begin
              bulk_left_next = acc;
              phase_next     = PH_DATA;
            end
          end else begin
            lines_seen_next = lines_inc;
            phase_next      = PH_LINE;
            done            = fin_done;
          end
        end
        PH_LINE: begin
          if (data_byte == CH_DOLLAR || data_byte == CH_COLON) begin
            kind_next  = (data_byte == CH_DOLLAR) ? KIND_BULK : KIND_INT;
            acc_next   = '0;
            neg_next   = 1'b0;
            phase_next = PH_NUM_FIRST;
          end else begin
            status = ST_PROTO;
          end
        end
        PH_DATA: begin
          if (bulk_left != '0) begin
            bulk_left_next = bulk_left - 1'b1;
          end
          if (bulk_left_next == '0) begin
            phase_next = PH_DATA_CR;
          end
        end
        PH_DATA_CR: begin
          if (data_byte == CH_CR) begin
            phase_next = PH_DATA_LF;
          end else begin
            status = ST_PROTO;
          end
        end
        PH_DATA_LF: begin
          if (data_byte == CH_LF) begin
            lines_seen_next = lines_inc;
            phase_next      = PH_LINE;
            done            = fin_done;
          end else begin
            status = ST_PROTO;
          end
        end
        default: begin
          status = ST_PROTO;
        end
      endcase
    end

    if (status != ST_OK) begin
      done = 1'b0;
    end
    lines_out = lines_seen_next;

    if (done || status != ST_OK) begin
      phase_next      = PH_ARRAY;
      acc_next        = '0;
      neg_next        = 1'b0;
      kind_next       = KIND_COUNT;
      lines_exp_next  = '0;
      lines_seen_next = '0;
      bulk_left_next  = '0;
      bytes_next      = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_ARRAY;
      acc        <= '0;
      neg        <= 1'b0;
      kind       <= KIND_COUNT;
      lines_exp  <= '0;
      lines_seen <= '0;
      bulk_left  <= '0;
      bytes      <= '0;
    end else if (step) begin
      phase      <= phase_next;
      acc        <= acc_next;
      neg        <= neg_next;
      kind       <= kind_next;
      lines_exp  <= lines_exp_next;
      lines_seen <= lines_seen_next;
      bulk_left  <= bulk_left_next;
      bytes      <= bytes_next;
    end
  end

  assign res.package_done = done;
  assign res.status       = status;
  assign res.req_length   = bytes_inc;
  assign res.lines_done   = lines_out;
endmodule

FILE: design/rrf_out_reg.sv
// Result register: holds one result word until the sink takes it.
module rrf_out_reg (
  input  logic                clk,
  input  logic                rst,
  input  logic                load,
  input  rrf_pkg::rrf_result_t d,
  output logic                free,
  rrf_result_if.source        result
);
  import rrf_pkg::*;

  logic        valid;
  rrf_result_t held;

  assign free = !valid || result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (free) begin
      valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= d;
    end
  end

  assign result.valid        = valid;
  assign result.package_done = held.package_done;
  assign result.status       = held.status;
  assign result.req_length   = held.req_length;
  assign result.lines_done   = held.lines_done;
endmodule

FILE: design/resp_request_framer_core.sv
// Request framer top level: input register, parser step, result register.
// Each accepted byte is stepped through the parser from the input register, and its result word
// is held in the result register. Throughput: one byte per cycle while the result sink takes
// words; the parser state register closes its loop through the decimal multiply-by-ten and the length compares.
// Reset (rst, synchronous): parser to the array-marker phase, counters cleared,
// both registers empty, max_req_length to 2097152.
module resp_request_framer_core (
  input  logic         clk,
  input  logic         rst,
  rrf_byte_if.sink     data,
  rrf_result_if.source result,
  rrf_cfg_if.sink      cfg
);
  import rrf_pkg::*;

  logic [LENGTH_BITS-1:0] max_len;
  rrf_item_t              item;
  rrf_result_t            res;
  logic                   free;
  logic                   step;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_len <= MAX_LEN_RESET;
    end else if (cfg.valid) begin
      max_len <= cfg.max_req_length;
    end
  end

  assign step = item.full && free;

  rrf_in_reg u_in (
    .clk  (clk),
    .rst  (rst),
    .data (data),
    .take (step),
    .item (item)
  );

  rrf_parse u_parse (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .data_byte (item.data_byte),
    .max_len   (max_len),
    .res       (res)
  );

  rrf_out_reg u_out (
    .clk    (clk),
    .rst    (rst),
    .load   (step),
    .d      (res),
    .free   (free),
    .result (result)
  );
endmodule

FILE: design/rrf_checker.sv
// Port-level checks for the request framer, bound to the top level.
module rrf_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic                            done,
  input logic [1:0]                      status,
  input logic [rrf_pkg::LENGTH_BITS-1:0] plen
);
  import rrf_pkg::*;

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped while stalled");

  a_done_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && done |-> status == ST_OK)
    else $error("request end flagged with error status");

  a_len_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> plen != '0)
    else $error("result word with zero length");

  a_min_request: assert property (@(posedge clk) disable iff (rst)
    out_valid && done |-> plen >= LENGTH_BITS'(4))
    else $error("request ended shorter than a minimal frame");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid right after reset");
endmodule

bind resp_request_framer_core rrf_checker u_rrf_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (result.valid),
  .out_ready (result.ready),
  .done      (result.package_done),
  .status    (result.status),
  .plen      (result.req_length)
);
